// File: rtl/core/htb_pkg.sv
// htb_pkg: shared types, character codes and end-marker tables for the HTML tag blanker.
// No dependencies; imported by every module of the block.
package htb_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;

  localparam int HASH_W = 22;
  localparam logic [HASH_W-1:0] HASH_MAX     = 22'h3FFFFF;
  localparam logic [HASH_W-1:0] HASH_COMMENT = 22'd441;
  localparam logic [HASH_W-1:0] HASH_SCRIPT  = 22'd3052;
  localparam logic [HASH_W-1:0] HASH_STYLE   = 22'd2268;

  localparam logic [1:0] COMMENT_LEN = 2'd3;
  localparam logic [3:0] SCRIPT_LEN  = 4'd8;
  localparam logic [2:0] STYLE_LEN   = 3'd7;

  // "/script>" and "/style>"
  localparam logic [7:0] MK_SCRIPT [8] = '{8'h2F, 8'h73, 8'h63, 8'h72,
                                           8'h69, 8'h70, 8'h74, 8'h3E};
  localparam logic [7:0] MK_STYLE [7] = '{8'h2F, 8'h73, 8'h74, 8'h79,
                                          8'h6C, 8'h65, 8'h3E};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } htb_item_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // "-->": a dash after "--" keeps two dashes matched
  function automatic logic [1:0] comment_adv(input logic [1:0] p, input logic [7:0] c);
    logic [1:0] q;
    q = (p == COMMENT_LEN) ? 2'd0 : p;
    if (q == 2'd2 && c == CH_GT) begin
      return 2'd3;
    end
    if (c == CH_DASH) begin
      return (q == 2'd0) ? 2'd1 : 2'd2;
    end
    return 2'd0;
  endfunction

  // all marker bytes distinct: a mismatch restarts on '/' only
  function automatic logic [3:0] script_adv(input logic [3:0] p, input logic [7:0] c);
    logic [2:0] idx;
    idx = (p >= SCRIPT_LEN) ? 3'd0 : p[2:0];
    if (c == MK_SCRIPT[idx]) begin
      return {1'b0, idx} + 4'd1;
    end
    return (c == CH_SLASH) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic [2:0] style_adv(input logic [2:0] p, input logic [7:0] c);
    logic [2:0] idx;
    idx = (p == STYLE_LEN) ? 3'd0 : p;
    if (c == MK_STYLE[idx]) begin
      return idx + 3'd1;
    end
    return (c == CH_SLASH) ? 3'd1 : 3'd0;
  endfunction

endpackage

// File: rtl/core/htb_ctrl.sv
// htb_ctrl: tag-tracking state, name hash and end-marker matchers; one byte per transaction.
// Depends on htb_pkg.
module htb_ctrl #(
  parameter int MAX_NAME = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  htb_pkg::htb_item_t item,
  output htb_pkg::htb_item_t res
);
  import htb_pkg::*;

  localparam int PW = $clog2(MAX_NAME + 1);
  localparam int SW = (PW + 9 > HASH_W + 1) ? PW + 9 : HASH_W + 1;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_NAME    = 3'd1,
    M_COMMENT = 3'd2,
    M_SCRIPT  = 3'd3,
    M_STYLE   = 3'd4,
    M_PLAIN   = 3'd5
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [1:0]        comm_r, comm_nxt;
  logic [3:0]        scr_r, scr_nxt;
  logic [2:0]        sty_r, sty_nxt;

  logic [7:0]    b, lc;
  logic [1:0]    comm_adv;
  logic [3:0]    scr_adv;
  logic [2:0]    sty_adv;
  logic [PW-1:0] pos_inc;
  logic [PW+7:0] prod;
  logic [SW-1:0] sum;
  logic          term;

  assign b        = item.text_byte;
  assign lc       = to_lower(b);
  assign comm_adv = comment_adv(comm_r, lc);
  assign scr_adv  = script_adv(scr_r, lc);
  assign sty_adv  = style_adv(sty_r, lc);
  assign pos_inc  = pos_r + 1'b1;
  assign prod     = pos_inc * b;
  assign sum      = SW'(hash_r) + SW'(prod);
  assign term     = (b == CH_SP) || (b == CH_GT);

  always_comb begin
    mode_nxt      = mode_r;
    hash_nxt      = hash_r;
    pos_nxt       = pos_r;
    comm_nxt      = comm_r;
    scr_nxt       = scr_r;
    sty_nxt       = sty_r;
    res.text_byte = CH_SP;
    res.last      = item.last;
    unique case (mode_r)
      M_NAME: begin
        comm_nxt = comm_adv;
        scr_nxt  = scr_adv;
        sty_nxt  = sty_adv;
        if (term) begin
          if (hash_r == HASH_COMMENT) begin
            mode_nxt = (comm_adv == COMMENT_LEN) ? M_NORMAL : M_COMMENT;
          end else if (hash_r == HASH_SCRIPT) begin
            mode_nxt = (scr_adv == SCRIPT_LEN) ? M_NORMAL : M_SCRIPT;
          end else if (hash_r == HASH_STYLE) begin
            mode_nxt = (sty_adv == STYLE_LEN) ? M_NORMAL : M_STYLE;
          end else begin
            mode_nxt = (b == CH_GT) ? M_NORMAL : M_PLAIN;
          end
        end else if (pos_r < PW'(MAX_NAME)) begin
          pos_nxt  = pos_inc;
          hash_nxt = (sum > SW'(HASH_MAX)) ? HASH_MAX : sum[HASH_W-1:0];
        end
      end
      M_COMMENT: begin
        comm_nxt = comm_adv;
        scr_nxt  = scr_adv;
        sty_nxt  = sty_adv;
        if (comm_adv == COMMENT_LEN) begin
          mode_nxt = M_NORMAL;
        end
      end
      M_SCRIPT: begin
        comm_nxt = comm_adv;
        scr_nxt  = scr_adv;
        sty_nxt  = sty_adv;
        if (scr_adv == SCRIPT_LEN) begin
          mode_nxt = M_NORMAL;
        end
      end
      M_STYLE: begin
        comm_nxt = comm_adv;
        scr_nxt  = scr_adv;
        sty_nxt  = sty_adv;
        if (sty_adv == STYLE_LEN) begin
          mode_nxt = M_NORMAL;
        end
      end
      M_PLAIN: begin
        if (b == CH_GT) begin
          mode_nxt = M_NORMAL;
        end
      end
      default: begin
        mode_nxt      = M_NORMAL;
        res.text_byte = b;
        if (b == CH_LT) begin
          res.text_byte = CH_SP;
          mode_nxt      = M_NAME;
          pos_nxt       = PW'(1);
          hash_nxt      = HASH_W'(CH_LT);
          comm_nxt      = comment_adv(2'd0, CH_LT);
          scr_nxt       = script_adv(4'd0, CH_LT);
          sty_nxt       = style_adv(3'd0, CH_LT);
        end
      end
    endcase
    if (item.last) begin
      mode_nxt = M_NORMAL;
      hash_nxt = '0;
      pos_nxt  = '0;
      comm_nxt = '0;
      scr_nxt  = '0;
      sty_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      hash_r <= '0;
      pos_r  <= '0;
      comm_r <= '0;
      scr_r  <= '0;
      sty_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      hash_r <= hash_nxt;
      pos_r  <= pos_nxt;
      comm_r <= comm_nxt;
      scr_r  <= scr_nxt;
      sty_r  <= sty_nxt;
    end
  end

endmodule

// File: rtl/core/htb_outreg.sv
// htb_outreg: result register with valid/ready; takes a new result while the old one leaves.
// Depends on htb_pkg.
module htb_outreg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  htb_pkg::htb_item_t res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import htb_pkg::*;

  logic      valid_r;
  htb_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_byte  = data_r.text_byte;
  assign out_last  = data_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

// File: rtl/core/html_tag_blanker_top.sv
// html_tag_blanker_top: streaming HTML tag blanker, one text byte in and one byte out.
// Depends on htb_pkg, htb_ctrl and htb_outreg.
//
// Usage: bytes of a text chunk enter on the in_ channel (in_text_byte, in_last marks
// the chunk's final byte). Each input transaction yields exactly one output
// transaction carrying the same byte, or a space when the byte lies inside a tag.
// A tag opens at '<'; its name hash selects whether it closes at "-->",
// "/script>", "/style>" or the next '>'. A tag still open at the final byte is
// blanked through it, and all tag state clears after every final byte.
// Timing: out_valid rises in the cycle after the input transaction.
// Throughput: one byte per cycle while the receiver does not stall; the tag state update
// is combinational (a narrow position-by-byte multiply, a saturating add) into its registers.
// Stall: in_ready = !out_valid || out_ready, so a byte is taken in the same cycle
// the waiting result leaves; while the receiver stalls the result holds and in_ready
// stays low.
// Reset: synchronous, active low; clears the tag state and drops out_valid.
module html_tag_blanker_top #(
  parameter int MAX_NAME = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import htb_pkg::*;

  htb_item_t item;
  htb_item_t res;
  logic      accept;

  assign item.text_byte = in_text_byte;
  assign item.last      = in_last;
  assign accept         = in_valid && in_ready;

  htb_ctrl #(
    .MAX_NAME(MAX_NAME)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (item),
    .res   (res)
  );

  htb_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res      (res),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// File: rtl/core/htb_checker.sv
// htb_checker: port-level assertions for html_tag_blanker_top, attached by bind.
// Depends on htb_pkg.
module htb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_text_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import htb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transaction");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_last == $past(in_last))
    else $error("out_last does not follow in_last");

  a_lt_blank: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_text_byte == CH_LT |=> out_byte == CH_SP)
    else $error("'<' was not blanked");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind html_tag_blanker_top htb_checker u_htb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_text_byte(in_text_byte),
  .in_last     (in_last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .out_last    (out_last)
);

// File: tb/tb_top.sv
// tb_top: self-checking testbench for html_tag_blanker_top.
// A scoreboard class predicts each blanked byte; plain tasks drive random HTML-like chunks.
// Depends on htb_pkg and the html_tag_blanker_top RTL.
import htb_pkg::*;

typedef enum logic [2:0] {
  TM_TEXT,
  TM_NAME,
  TM_COMMENT,
  TM_SCRIPT,
  TM_STYLE,
  TM_PLAIN
} tag_mode_t;

class blank_scoreboard;
  int unsigned name_limit;
  tag_mode_t   mode;
  int unsigned name_sum;
  int unsigned name_len;
  int          comment_seen;
  int          script_seen;
  int          style_seen;
  logic [7:0]  blanked_bytes[$];
  logic        blanked_lasts[$];
  int          errors;

  function new(int unsigned limit);
    name_limit = limit;
    errors = 0;
    clear_tag();
  endfunction

  function void clear_tag();
    mode = TM_TEXT;
    name_sum = 0;
    name_len = 0;
    comment_seen = 0;
    script_seen = 0;
    style_seen = 0;
  endfunction

  // longest marker prefix that ends the bytes seen so far
  function int marker_step(string mk, int p, logic [7:0] c);
    int k;
    int i;
    bit ok;
    if (p >= mk.len()) p = 0;
    for (k = p + 1; k > 0; k--) begin
      ok = (mk[k-1] == c);
      for (i = 0; ok && i < k - 1; i++) ok = (mk[i] == mk[p-k+1+i]);
      if (ok) return k;
    end
    return 0;
  endfunction

  function void scan_markers(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + 8'd32 : c;
    comment_seen = marker_step("-->", comment_seen, lc);
    script_seen = marker_step("/script>", script_seen, lc);
    style_seen = marker_step("/style>", style_seen, lc);
  endfunction

  function bit marker_closed();
    case (mode)
      TM_COMMENT: return comment_seen == COMMENT_LEN;
      TM_SCRIPT:  return script_seen == SCRIPT_LEN;
      TM_STYLE:   return style_seen == STYLE_LEN;
      default:    return 1'b0;
    endcase
  endfunction

  function void predict_blank(logic [7:0] b, logic l);
    logic [7:0]  ob;
    int unsigned add;
    ob = CH_SP;
    case (mode)
      TM_TEXT: begin
        ob = b;
        if (b == CH_LT) begin
          ob = CH_SP;
          mode = TM_NAME;
          name_len = 1;
          name_sum = 32'(CH_LT);
          comment_seen = 0;
          script_seen = 0;
          style_seen = 0;
          scan_markers(b);
        end
      end
      TM_NAME: begin
        scan_markers(b);
        if (b == CH_SP || b == CH_GT) begin
          if (name_sum == HASH_COMMENT) mode = TM_COMMENT;
          else if (name_sum == HASH_SCRIPT) mode = TM_SCRIPT;
          else if (name_sum == HASH_STYLE) mode = TM_STYLE;
          else mode = TM_PLAIN;
          if (mode == TM_PLAIN) begin
            if (b == CH_GT) mode = TM_TEXT;
          end else if (marker_closed()) begin
            mode = TM_TEXT;
          end
        end else if (name_len < name_limit) begin
          name_len++;
          add = name_len * b;
          if (name_sum > HASH_MAX - add) name_sum = 32'(HASH_MAX);
          else name_sum += add;
        end
      end
      TM_PLAIN: begin
        if (b == CH_GT) mode = TM_TEXT;
      end
      default: begin
        scan_markers(b);
        if (marker_closed()) mode = TM_TEXT;
      end
    endcase
    if (l) clear_tag();
    blanked_bytes.push_back(ob);
    blanked_lasts.push_back(l);
  endfunction

  function void check_byte(logic [7:0] b, logic l);
    logic [7:0] want_b;
    logic       want_l;
    if (blanked_bytes.size() == 0) begin
      $display("%0t: unexpected output transaction, byte %02h last %0d", $time, b, l);
      errors++;
      return;
    end
    want_b = blanked_bytes.pop_front();
    want_l = blanked_lasts.pop_front();
    if (b !== want_b) begin
      $display("%0t: out_byte expected %02h actual %02h", $time, want_b, b);
      errors++;
    end
    if (l !== want_l) begin
      $display("%0t: out_last expected %0d actual %0d", $time, want_l, l);
      errors++;
    end
  endfunction

  function int pending();
    return blanked_bytes.size();
  endfunction
endclass

module tb_top;
  localparam int NAME_LIMIT = 200;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int cycle_count = 0;
  int recv_count = 0;

  blank_scoreboard sb;
  logic [7:0] stim_byte[$];
  logic       stim_last[$];

  html_tag_blanker_top #(
    .MAX_NAME(NAME_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_text_byte(in_text_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender and receiver stall freely except in one window of steady traffic
  always @(posedge clk) begin
    out_ready <= (recv_count >= 250 && recv_count < 450) || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.predict_blank(in_text_byte, in_last);
      if (out_valid && out_ready) begin
        sb.check_byte(out_byte, out_last);
        recv_count <= recv_count + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stim_byte.push_back(b);
    stim_last.push_back(1'b0);
  endtask

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic end_chunk();
    stim_last[stim_last.size()-1] = 1'b1;
  endtask

  // end marker with letters in random case
  task automatic put_marker(input string s);
    int i;
    logic [7:0] b;
    for (i = 0; i < s.len(); i++) begin
      b = s[i];
      if (b >= "a" && b <= "z" && $urandom_range(3) == 0) b = b - 8'd32;
      push_byte(b);
    end
  endtask

  task automatic put_body();
    int n;
    int k;
    logic [7:0] b;
    n = $urandom_range(0, 8);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(7))
        0: b = CH_DASH;
        1: b = CH_GT;
        2: b = CH_SLASH;
        3: b = CH_LT;
        4: b = 8'("a" + $urandom_range(25));
        5: b = 8'("A" + $urandom_range(25));
        default: b = 8'($urandom_range(1, 255));
      endcase
      push_byte(b);
    end
  endtask

  // long names, some past the summing limit; high bytes push the sum toward saturation
  task automatic put_long_name(input bit heavy);
    int n;
    int k;
    logic [7:0] b;
    n = heavy ? $urandom_range(195, 230) : $urandom_range(100, 210);
    push_byte(CH_LT);
    for (k = 0; k < n; k++) begin
      do b = 8'(heavy ? $urandom_range(200, 255) : $urandom_range(1, 255));
      while (b == CH_SP || b == CH_GT);
      push_byte(b);
    end
    push_byte(CH_GT);
  endtask

  task automatic put_segment();
    int n;
    int k;
    logic [7:0] b;
    case ($urandom_range(11))
      0, 1: begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_LT) b = CH_SP;
          push_byte(b);
        end
      end
      2: begin
        push_byte(CH_LT);
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) push_byte(8'("a" + $urandom_range(25)));
        if ($urandom_range(1)) put_str(" id=v");
        push_byte(CH_GT);
      end
      3: begin
        put_str("<!-- ");
        put_body();
        put_marker("-->");
      end
      4: begin
        if ($urandom_range(1)) put_str("<script>");
        else put_str("<script src=a>");
        put_body();
        push_byte(CH_LT);
        put_marker("/script>");
      end
      5: begin
        if ($urandom_range(1)) put_str("<style>");
        else put_str("<style media=x>");
        put_body();
        push_byte(CH_LT);
        put_marker("/style>");
      end
      6: begin
        if ($urandom_range(1)) put_str("<SCRIPT>");
        else put_str("<Style>");
        put_body();
      end
      7, 8: put_body();
      9: begin
        case ($urandom_range(3))
          0: put_str("<!-- ");
          1: put_str("<script>");
          2: put_str("<style>");
          default: put_str("<em");
        endcase
        put_body();
        if ($urandom_range(1)) put_str("</sty");
      end
      10: begin
        if ($urandom_range(1)) put_str("<>");
        else put_str("< b>");
      end
      default: begin
        if ($urandom_range(59) == 0) put_long_name(1'($urandom_range(1)));
        else put_body();
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit steady);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_last <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int n;
    int k;
    int first_random;
    sb = new(NAME_LIMIT);

    // directed: byte extremes, comment closed by its own name, lone '<' in a tag,
    // missing end at chunk end, state cleared for the next chunk
    push_byte(8'h01);
    end_chunk();
    push_byte(8'hFF);
    end_chunk();
    put_str("<!-->x");
    end_chunk();
    put_str("a<b<>c");
    end_chunk();
    put_str("<p");
    end_chunk();
    put_str("q");
    end_chunk();
    put_str("<i x>y");
    end_chunk();

    first_random = stim_byte.size();
    put_long_name(1'b1);
    put_str("z");
    put_long_name(1'b0);
    end_chunk();
    while (stim_byte.size() < first_random + RANDOM_ITEMS) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) put_segment();
      end_chunk();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stim_byte[i]) send_byte(stim_byte[i], stim_last[i], i >= 250 && i < 450);
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
